/* src/best_fit_hole_allocator_unit_macros.svh */
// Assertion macros used by the checker file.
`ifndef BEST_FIT_HOLE_ALLOCATOR_UNIT_MACROS_SVH
`define BEST_FIT_HOLE_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication.
`define BFHA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BFHA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/bfha_pkg.sv */
// ----------------------------------------------------------------------------
// bfha_pkg
// Types and constants of the best-fit hole allocator.
// ----------------------------------------------------------------------------
package bfha_pkg;

    localparam int HOLE_SLOTS_DEF  = 64;
    localparam int OFFSET_BITS_DEF = 32;

    localparam int SIZE_W   = 25;
    localparam int BYTES_W  = 31;
    localparam int GRAN_W   = 17;
    localparam int PORT_OFF_W = 32;
    localparam int TOTAL_W  = 7;
    localparam int DCNT_W   = $clog2(SIZE_W + 1);

    localparam logic [GRAN_W-1:0] GRANULE_RST = 17'd512;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NOSPACE = 2'd2;

    localparam logic FUNC_ALLOC   = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan_init;
        logic scan_step;
        logic shift_init;
        logic shift_step;
        logic div_init;
        logic div_step;
        logic round;
        logic commit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic func;
        logic full;
        logic found;
        logic scan_done;
        logic shift_done;
        logic div_done;
    } t_sts;

endpackage

/* src/bfha_ram.sv */
// ----------------------------------------------------------------------------
// bfha_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/bfha_ctrl.sv */
// ----------------------------------------------------------------------------
// bfha_ctrl
// Sequencer: check, scan, shift or divide and round, commit; or check, commit.
// ----------------------------------------------------------------------------
module bfha_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    output logic           o_valid,
    input  logic           i_stall,
    input  bfha_pkg::t_sts i_sts,
    output bfha_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHK   = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_ROUND = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_ovalid, n_ovalid;
    logic       out_free;

    assign out_free = !r_ovalid || !i_stall;

    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid && i_stall;
        o_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHK;
                end
            end
            S_CHK: begin
                if (i_sts.func == bfha_pkg::FUNC_RELEASE && i_sts.full) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    if (i_sts.func == bfha_pkg::FUNC_ALLOC && !i_sts.found) begin
                        o_cmd.div_init = 1'b1;
                        n_state        = S_DIV;
                    end else begin
                        o_cmd.shift_init = 1'b1;
                        n_state          = S_SHIFT;
                    end
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_SHIFT: begin
                if (i_sts.shift_done) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.shift_step = 1'b1;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_ROUND;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                n_state     = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_ovalid     = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;

endmodule

/* src/bfha_dpath.sv */
// ----------------------------------------------------------------------------
// bfha_dpath
// Hole store, scan and shift pointers, remainder unit, totals, result register.
// ----------------------------------------------------------------------------
module bfha_dpath #(
    parameter int HOLE_SLOTS  = bfha_pkg::HOLE_SLOTS_DEF,
    parameter int OFFSET_BITS = bfha_pkg::OFFSET_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  bfha_pkg::t_cmd                    i_cmd,
    output bfha_pkg::t_sts                    o_sts,
    input  logic                              i_cfg_wr_en,
    input  logic [bfha_pkg::GRAN_W-1:0]       i_cfg_wr_data,
    input  logic                              i_func,
    input  logic [bfha_pkg::SIZE_W-1:0]       i_req_size,
    input  logic [bfha_pkg::PORT_OFF_W-1:0]   i_rel_offset,
    input  logic [bfha_pkg::SIZE_W-1:0]       i_rel_size,
    output logic [bfha_pkg::PORT_OFF_W-1:0]   o_grant_offset,
    output logic [bfha_pkg::SIZE_W-1:0]       o_grant_size,
    output logic                              o_reused,
    output logic [1:0]                        o_status,
    output logic [bfha_pkg::TOTAL_W-1:0]      o_hole_total,
    output logic [bfha_pkg::BYTES_W-1:0]      o_hole_byte_total,
    output logic [bfha_pkg::PORT_OFF_W-1:0]   o_end_offset
);

    localparam int SW    = bfha_pkg::SIZE_W;
    localparam int GW    = bfha_pkg::GRAN_W;
    localparam int BW    = bfha_pkg::BYTES_W;
    localparam int AW    = $clog2(HOLE_SLOTS);
    localparam int CW    = $clog2(HOLE_SLOTS + 1);
    localparam int ENT_W = OFFSET_BITS + SW;
    localparam int EW    = ((OFFSET_BITS > SW + 1) ? OFFSET_BITS : SW + 1) + 1;
    localparam logic [CW-1:0] SLOTS_C = CW'(HOLE_SLOTS);

    // architectural state
    logic [GW-1:0]          r_granule;
    logic [CW-1:0]          r_count, n_count;
    logic [BW-1:0]          r_bytes, n_bytes;
    logic [OFFSET_BITS-1:0] r_end, n_end;

    // request
    logic                   r_func;
    logic [SW-1:0]          r_key;
    logic [OFFSET_BITS-1:0] r_roff;

    // scan / shift
    logic [CW-1:0]          r_idx;
    logic [AW-1:0]          r_pidx;
    logic                   r_pend;
    logic                   r_found;
    logic [CW-1:0]          r_pos;
    logic [OFFSET_BITS-1:0] r_hoff;
    logic [SW-1:0]          r_hsz;
    logic [CW-1:0]          r_src;
    logic [AW-1:0]          r_dst;
    logic [CW-1:0]          r_left;

    // remainder unit
    logic [GW-1:0]          r_rem;
    logic [SW-1:0]          r_num;
    logic [bfha_pkg::DCNT_W-1:0] r_dcnt;
    logic [SW:0]            r_fsize;

    // result register
    logic [bfha_pkg::PORT_OFF_W-1:0] r_goff;
    logic [SW-1:0]          r_gsz;
    logic                   r_reused;
    logic [1:0]             r_status;
    logic [bfha_pkg::TOTAL_W-1:0] r_total;
    logic [BW-1:0]          r_btotal;
    logic [bfha_pkg::PORT_OFF_W-1:0] r_eoff;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr, ram_raddr;
    logic [ENT_W-1:0]       ram_wdata, ram_rdata;
    logic [SW-1:0]          rd_size;
    logic [OFFSET_BITS-1:0] rd_off;

    logic [GW-1:0]          g_eff;
    logic                   hit, scan_issue, shift_issue;
    logic [BW:0]            bsum;
    logic                   full;
    logic [GW:0]            div_t;
    logic                   div_ge;
    logic [EW-1:0]          new_end;
    logic                   fresh_ok;
    logic                   k_full, k_ins, k_rm, k_fresh;
    logic [CW-1:0]          src_up, src_dn;

    bfha_ram #(
        .WIDTH (ENT_W),
        .DEPTH (HOLE_SLOTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_size = ram_rdata[SW-1:0];
    assign rd_off  = ram_rdata[ENT_W-1:SW];

    assign g_eff       = (r_granule == '0) ? GW'(1) : r_granule;
    assign hit         = r_pend && (rd_size >= r_key);
    assign scan_issue  = !hit && (r_idx < r_count);
    assign shift_issue = (r_left != '0);
    assign src_up      = r_src + CW'(1);
    assign src_dn      = r_src - CW'(1);

    assign bsum = {1'b0, r_bytes} + (BW + 1)'(r_key);
    assign full = (r_count >= SLOTS_C) || bsum[BW];

    assign div_t  = {r_rem, r_num[SW-1]};
    assign div_ge = (div_t >= {1'b0, g_eff});

    assign new_end  = EW'(r_end) + EW'(r_fsize);
    assign fresh_ok = !r_fsize[SW] && (new_end[EW-1:OFFSET_BITS] == '0);

    assign k_full  = r_func && full;
    assign k_ins   = r_func && !full;
    assign k_rm    = !r_func && r_found;
    assign k_fresh = !r_func && !r_found;

    // store ports: shift moves entries, insert commit drops the new hole in
    assign ram_raddr = i_cmd.shift_step ? r_src[AW-1:0] : r_idx[AW-1:0];
    assign ram_we    = (i_cmd.shift_step && r_pend) || (i_cmd.commit && k_ins);
    assign ram_waddr = i_cmd.shift_step ? r_dst : r_pos[AW-1:0];
    assign ram_wdata = i_cmd.shift_step ? ram_rdata : {r_roff, r_key};

    always_comb begin
        n_count = r_count;
        n_bytes = r_bytes;
        n_end   = r_end;
        if (k_ins) begin
            n_count = r_count + CW'(1);
            n_bytes = bsum[BW-1:0];
        end else if (k_rm) begin
            n_count = r_count - CW'(1);
            n_bytes = r_bytes - BW'(r_hsz);
        end else if (k_fresh && fresh_ok) begin
            n_end = new_end[OFFSET_BITS-1:0];
        end
    end

    assign o_sts.func       = r_func;
    assign o_sts.full       = full;
    assign o_sts.found      = r_found;
    assign o_sts.scan_done  = r_found || (!r_pend && (r_idx >= r_count));
    assign o_sts.shift_done = !r_pend && (r_left == '0);
    assign o_sts.div_done   = (r_dcnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_granule <= bfha_pkg::GRANULE_RST;
            r_count   <= '0;
            r_bytes   <= '0;
            r_end     <= '0;
            r_pend    <= 1'b0;
            r_found   <= 1'b0;
            r_func    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_granule <= i_cfg_wr_data;
            end
            if (i_cmd.load) begin
                r_func <= i_func;
            end
            if (i_cmd.scan_init) begin
                r_pend  <= 1'b0;
                r_found <= 1'b0;
            end
            if (i_cmd.scan_step) begin
                if (hit) begin
                    r_found <= 1'b1;
                    r_pend  <= 1'b0;
                end else begin
                    r_pend <= scan_issue;
                end
            end
            if (i_cmd.shift_init) begin
                r_pend <= 1'b0;
            end
            if (i_cmd.shift_step) begin
                r_pend <= shift_issue;
            end
            if (i_cmd.commit) begin
                r_count <= n_count;
                r_bytes <= n_bytes;
                r_end   <= n_end;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key  <= (i_func == bfha_pkg::FUNC_RELEASE) ? i_rel_size : i_req_size;
            r_roff <= OFFSET_BITS'(i_rel_offset);
        end
        if (i_cmd.scan_init) begin
            r_idx <= '0;
            r_pos <= r_count;
        end
        if (i_cmd.scan_step) begin
            if (hit) begin
                r_pos  <= CW'(r_pidx);
                r_hoff <= rd_off;
                r_hsz  <= rd_size;
            end else if (scan_issue) begin
                r_pidx <= r_idx[AW-1:0];
                r_idx  <= r_idx + CW'(1);
            end
        end
        // release opens a gap at the insert point, allocate closes the taken one
        if (i_cmd.shift_init) begin
            if (r_func == bfha_pkg::FUNC_RELEASE) begin
                r_src  <= r_count - CW'(1);
                r_left <= r_count - r_pos;
            end else begin
                r_src  <= r_pos + CW'(1);
                r_left <= r_count - r_pos - CW'(1);
            end
        end
        if (i_cmd.shift_step && shift_issue) begin
            if (r_func == bfha_pkg::FUNC_RELEASE) begin
                r_dst <= src_up[AW-1:0];
                r_src <= src_dn;
            end else begin
                r_dst <= src_dn[AW-1:0];
                r_src <= src_up;
            end
            r_left <= r_left - CW'(1);
        end
        // restoring remainder, one numerator bit per cycle
        if (i_cmd.div_init) begin
            r_rem  <= '0;
            r_num  <= r_key;
            r_dcnt <= bfha_pkg::DCNT_W'(SW);
        end
        if (i_cmd.div_step) begin
            r_rem  <= div_ge ? GW'(div_t - {1'b0, g_eff}) : div_t[GW-1:0];
            r_num  <= {r_num[SW-2:0], 1'b0};
            r_dcnt <= r_dcnt - bfha_pkg::DCNT_W'(1);
        end
        if (i_cmd.round) begin
            r_fsize <= (r_rem == '0) ? {1'b0, r_key}
                     : {1'b0, r_key} + (SW + 1)'(g_eff) - (SW + 1)'(r_rem);
        end
        if (i_cmd.commit) begin
            r_goff   <= '0;
            r_gsz    <= '0;
            r_reused <= 1'b0;
            r_status <= bfha_pkg::ST_OK;
            if (k_full) begin
                r_status <= bfha_pkg::ST_FULL;
            end else if (k_rm) begin
                r_goff   <= bfha_pkg::PORT_OFF_W'(r_hoff);
                r_gsz    <= r_hsz;
                r_reused <= 1'b1;
            end else if (k_fresh) begin
                if (fresh_ok) begin
                    r_goff <= bfha_pkg::PORT_OFF_W'(r_end);
                    r_gsz  <= r_fsize[SW-1:0];
                end else begin
                    r_status <= bfha_pkg::ST_NOSPACE;
                end
            end
            r_total  <= bfha_pkg::TOTAL_W'(n_count);
            r_btotal <= n_bytes;
            r_eoff   <= bfha_pkg::PORT_OFF_W'(n_end);
        end
    end

    assign o_grant_offset    = r_goff;
    assign o_grant_size      = r_gsz;
    assign o_reused          = r_reused;
    assign o_status          = r_status;
    assign o_hole_total      = r_total;
    assign o_hole_byte_total = r_btotal;
    assign o_end_offset      = r_eoff;

endmodule

/* src/best_fit_hole_allocator_unit.sv */
// ----------------------------------------------------------------------------
// best_fit_hole_allocator_unit
// Best-fit region allocator: size-ordered hole list, fresh space at file end.
// ----------------------------------------------------------------------------
// One request at a time. The hole list sits in a single-port-read RAM and is
// walked one entry per cycle, so the time per request follows the list. An
// allocate that finds a hole scans to the hit and then closes the gap; an
// allocate with no fitting hole runs the bit-serial remainder unit and then
// a rounding step to round the request up to the granule; a release scans
// for its insert point and then opens a gap inside the list or appends. A
// release into a full store answers without a scan. A finished result waits
// in the output register while the next request is taken in.
module best_fit_hole_allocator_unit #(
    parameter int HOLE_SLOTS  = bfha_pkg::HOLE_SLOTS_DEF,
    parameter int OFFSET_BITS = bfha_pkg::OFFSET_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [bfha_pkg::GRAN_W-1:0]       i_cfg_wr_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_func,
    input  logic [bfha_pkg::SIZE_W-1:0]       i_req_size,
    input  logic [bfha_pkg::PORT_OFF_W-1:0]   i_rel_offset,
    input  logic [bfha_pkg::SIZE_W-1:0]       i_rel_size,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [bfha_pkg::PORT_OFF_W-1:0]   o_grant_offset,
    output logic [bfha_pkg::SIZE_W-1:0]       o_grant_size,
    output logic                              o_reused,
    output logic [1:0]                        o_status,
    output logic [bfha_pkg::TOTAL_W-1:0]      o_hole_total,
    output logic [bfha_pkg::BYTES_W-1:0]      o_hole_byte_total,
    output logic [bfha_pkg::PORT_OFF_W-1:0]   o_end_offset
);

    bfha_pkg::t_cmd cmd;
    bfha_pkg::t_sts sts;

    bfha_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    bfha_dpath #(
        .HOLE_SLOTS  (HOLE_SLOTS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_func            (i_func),
        .i_req_size        (i_req_size),
        .i_rel_offset      (i_rel_offset),
        .i_rel_size        (i_rel_size),
        .o_grant_offset    (o_grant_offset),
        .o_grant_size      (o_grant_size),
        .o_reused          (o_reused),
        .o_status          (o_status),
        .o_hole_total      (o_hole_total),
        .o_hole_byte_total (o_hole_byte_total),
        .o_end_offset      (o_end_offset)
    );

endmodule

/* src/bfha_checker.sv */
// ----------------------------------------------------------------------------
// bfha_checker
// Port-level checks on the allocator's result channel.
// ----------------------------------------------------------------------------
`include "best_fit_hole_allocator_unit_macros.svh"

module bfha_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic [bfha_pkg::PORT_OFF_W-1:0]   o_grant_offset,
    input logic [bfha_pkg::SIZE_W-1:0]       o_grant_size,
    input logic                              o_reused,
    input logic [1:0]                        o_status,
    input logic [bfha_pkg::PORT_OFF_W-1:0]   o_end_offset
);

    `BFHA_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_grant_offset) && $stable(o_status) && $stable(o_end_offset), "stalled result changed")
    `BFHA_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, o_valid && (o_status != bfha_pkg::ST_OK), (o_grant_offset == '0) && (o_grant_size == '0) && !o_reused, "failed request carries a grant")
    `BFHA_ASSERT_IMP(a_reuse_ok, i_clk, i_rst_n, o_valid && o_reused, o_status == bfha_pkg::ST_OK, "reused grant with error status")

endmodule

bind best_fit_hole_allocator_unit bfha_checker u_bfha_checker (.*);

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Randomized test of the best-fit hole allocator. An in-bench model of the
// size-ordered hole list and the file end predicts every grant; results are
// compared field by field in order. Covers granule settings, a full hole
// store and running out of address space.
// ----------------------------------------------------------------------------
module tb_top;

    typedef struct {
        logic                        func;
        logic [bfha_pkg::SIZE_W-1:0] req_size;
        logic [31:0]                 rel_offset;
        logic [bfha_pkg::SIZE_W-1:0] rel_size;
    } t_request;

    typedef struct {
        logic [31:0]                  grant_offset;
        logic [bfha_pkg::SIZE_W-1:0]  grant_size;
        logic                         reused;
        logic [1:0]                   status;
        logic [bfha_pkg::TOTAL_W-1:0] hole_total;
        logic [bfha_pkg::BYTES_W-1:0] hole_byte_total;
        logic [31:0]                  end_offset;
    } t_grant;

    localparam longint unsigned SIZE_MAX  = 64'h1FF_FFFF;
    localparam longint unsigned BYTES_MAX = 64'h7FFF_FFFF;
    localparam longint unsigned OFF_MAX   = 64'hFFFF_FFFF;
    localparam int              SLOTS     = bfha_pkg::HOLE_SLOTS_DEF;

    // Allocator model plus the queue of grants it has promised.
    class alloc_scoreboard;
        longint unsigned hole_off [SLOTS];
        longint unsigned hole_sz [SLOTS];
        int              hole_cnt;
        longint unsigned hole_bytes;
        longint unsigned space_end;
        longint unsigned granule;
        t_grant          grants_due[$];
        int              errors;

        function new();
            hole_cnt   = 0;
            hole_bytes = 0;
            space_end  = 0;
            granule    = bfha_pkg::GRANULE_RST;
            errors     = 0;
        endfunction

        function void set_granule(logic [bfha_pkg::GRAN_W-1:0] v);
            granule = v;
        endfunction

        function t_grant make(longint unsigned off, longint unsigned sz, bit ru,
                              logic [1:0] st);
            t_grant g;
            g.grant_offset    = off[31:0];
            g.grant_size      = sz[bfha_pkg::SIZE_W-1:0];
            g.reused          = ru;
            g.status          = st;
            g.hole_total      = hole_cnt[bfha_pkg::TOTAL_W-1:0];
            g.hole_byte_total = hole_bytes[bfha_pkg::BYTES_W-1:0];
            g.end_offset      = space_end[31:0];
            return g;
        endfunction

        function void note_request(t_request r);
            longint unsigned req, gr, sz, off, ne;
            int pos;
            if (r.func == bfha_pkg::FUNC_ALLOC) begin
                req = r.req_size;
                for (int i = 0; i < hole_cnt; i++) begin
                    if (hole_sz[i] >= req) begin
                        off = hole_off[i];
                        sz  = hole_sz[i];
                        for (int j = i; j + 1 < hole_cnt; j++) begin
                            hole_off[j] = hole_off[j+1];
                            hole_sz[j]  = hole_sz[j+1];
                        end
                        hole_cnt--;
                        hole_bytes = (hole_bytes - sz) & BYTES_MAX;
                        grants_due.push_back(make(off, sz, 1'b1, bfha_pkg::ST_OK));
                        return;
                    end
                end
                gr = (granule == 0) ? 1 : granule;
                sz = ((req + gr - 1) / gr) * gr;
                ne = space_end + sz;
                if (sz > SIZE_MAX || ne > OFF_MAX) begin
                    grants_due.push_back(make(0, 0, 1'b0, bfha_pkg::ST_NOSPACE));
                end else begin
                    off = space_end;
                    space_end = ne;
                    grants_due.push_back(make(off, sz, 1'b0, bfha_pkg::ST_OK));
                end
            end else begin
                sz = r.rel_size;
                if (hole_cnt >= SLOTS || hole_bytes + sz > BYTES_MAX) begin
                    grants_due.push_back(make(0, 0, 1'b0, bfha_pkg::ST_FULL));
                    return;
                end
                pos = 0;
                while (pos < hole_cnt && hole_sz[pos] < sz) pos++;
                for (int j = hole_cnt; j > pos; j--) begin
                    hole_off[j] = hole_off[j-1];
                    hole_sz[j]  = hole_sz[j-1];
                end
                hole_off[pos] = r.rel_offset;
                hole_sz[pos]  = sz;
                hole_cnt++;
                hole_bytes += sz;
                grants_due.push_back(make(0, 0, 1'b0, bfha_pkg::ST_OK));
            end
        endfunction

        task report(string what, longint unsigned got, longint unsigned want);
            $display("mismatch %s: got %0h expected %0h", what, got, want);
            errors++;
        endtask

        task check_grant(t_grant g);
            t_grant e;
            if (grants_due.size() == 0) begin
                report("unexpected grant, offset", g.grant_offset, 0);
                return;
            end
            e = grants_due.pop_front();
            if (g.grant_offset !== e.grant_offset)
                report("grant_offset", g.grant_offset, e.grant_offset);
            if (g.grant_size !== e.grant_size)
                report("grant_size", g.grant_size, e.grant_size);
            if (g.reused !== e.reused) report("reused", g.reused, e.reused);
            if (g.status !== e.status) report("status", g.status, e.status);
            if (g.hole_total !== e.hole_total)
                report("hole_total", g.hole_total, e.hole_total);
            if (g.hole_byte_total !== e.hole_byte_total)
                report("hole_byte_total", g.hole_byte_total, e.hole_byte_total);
            if (g.end_offset !== e.end_offset)
                report("end_offset", g.end_offset, e.end_offset);
        endtask
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_cfg_wr_en;
    logic [bfha_pkg::GRAN_W-1:0]  i_cfg_wr_data;
    logic                         i_valid;
    logic                         o_stall;
    logic                         i_func;
    logic [bfha_pkg::SIZE_W-1:0]  i_req_size;
    logic [31:0]                  i_rel_offset;
    logic [bfha_pkg::SIZE_W-1:0]  i_rel_size;
    logic                         o_valid;
    logic                         i_stall;
    logic [31:0]                  o_grant_offset;
    logic [bfha_pkg::SIZE_W-1:0]  o_grant_size;
    logic                         o_reused;
    logic [1:0]                   o_status;
    logic [bfha_pkg::TOTAL_W-1:0] o_hole_total;
    logic [bfha_pkg::BYTES_W-1:0] o_hole_byte_total;
    logic [31:0]                  o_end_offset;

    alloc_scoreboard sb;
    int              req_taken;
    bit              hold_done;

    best_fit_hole_allocator_unit u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_func            (i_func),
        .i_req_size        (i_req_size),
        .i_rel_offset      (i_rel_offset),
        .i_rel_size        (i_rel_size),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_grant_offset    (o_grant_offset),
        .o_grant_size      (o_grant_size),
        .o_reused          (o_reused),
        .o_status          (o_status),
        .o_hole_total      (o_hole_total),
        .o_hole_byte_total (o_hole_byte_total),
        .o_end_offset      (o_end_offset)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic bit calm();
        return req_taken >= 150 && req_taken < 230;
    endfunction

    function automatic bit idle_now();
        return !calm() && $urandom_range(99) < 27;
    endfunction

    task automatic send_request(t_request r);
        while (idle_now()) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
        @(negedge i_clk);
        i_valid      = 1'b1;
        i_func       = r.func;
        i_req_size   = r.req_size;
        i_rel_offset = r.rel_offset;
        i_rel_size   = r.rel_size;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_request(r);
        req_taken++;
    endtask

    task automatic alloc(logic [bfha_pkg::SIZE_W-1:0] sz);
        t_request r;
        r.func       = bfha_pkg::FUNC_ALLOC;
        r.req_size   = sz;
        r.rel_offset = $urandom;
        r.rel_size   = bfha_pkg::SIZE_W'($urandom);
        send_request(r);
    endtask

    task automatic release_region(logic [31:0] off, logic [bfha_pkg::SIZE_W-1:0] sz);
        t_request r;
        r.func       = bfha_pkg::FUNC_RELEASE;
        r.req_size   = bfha_pkg::SIZE_W'($urandom);
        r.rel_offset = off;
        r.rel_size   = sz;
        send_request(r);
    endtask

    // Granule writes only reach the config port once the block has drained.
    task automatic write_granule(logic [bfha_pkg::GRAN_W-1:0] v);
        @(negedge i_clk);
        i_valid = 1'b0;
        while (sb.grants_due.size() != 0) @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = v;
        sb.set_granule(v);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    function automatic logic [bfha_pkg::SIZE_W-1:0] pick_size();
        int k;
        k = $urandom_range(9);
        if (k < 4) return bfha_pkg::SIZE_W'($urandom_range(4096));
        if (k < 6 && sb.hole_cnt > 0)
            return bfha_pkg::SIZE_W'(sb.hole_sz[$urandom_range(sb.hole_cnt - 1)]);
        if (k == 6) return 25'h100_0000;
        return bfha_pkg::SIZE_W'($urandom_range(25'h100_0000));
    endfunction

    task automatic random_requests(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(1) == 0) alloc(pick_size());
            else release_region($urandom, pick_size());
        end
    endtask

    // receiver: random stalls, one long hold-off after the first 60 requests
    initial begin
        i_stall = 1'b0;
        hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && req_taken >= 60) begin
                hold_done = 1'b1;
                i_stall = 1'b1;
                repeat (400) @(negedge i_clk);
            end
            i_stall = idle_now();
        end
    end

    always @(posedge i_clk) begin
        t_grant g;
        if (i_rst_n && o_valid && !i_stall) begin
            g.grant_offset    = o_grant_offset;
            g.grant_size      = o_grant_size;
            g.reused          = o_reused;
            g.status          = o_status;
            g.hole_total      = o_hole_total;
            g.hole_byte_total = o_hole_byte_total;
            g.end_offset      = o_end_offset;
            sb.check_grant(g);
        end
    end

    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end

    initial begin
        int guard;
        sb = new();
        req_taken     = 0;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        i_valid       = 1'b0;
        i_func        = bfha_pkg::FUNC_ALLOC;
        i_req_size    = '0;
        i_rel_offset  = '0;
        i_rel_size    = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty list, zero sizes, edge offsets, exact fits
        alloc(0);
        alloc(1);
        alloc(513);
        release_region(32'hFFFF_FFFF, 25'h100_0000);
        release_region(32'h0, 0);
        release_region(32'h1234_5678, 512);
        release_region(32'hDEAD_0000, 512);
        alloc(0);
        alloc(512);
        alloc(25'h100_0000);
        alloc(512);
        alloc(25'h100_0000);
        release_region(32'hAAAA_AAAA, 25'h0AA_AAAA);
        release_region(32'h5555_5555, 25'h155_5555 & 25'h0FF_FFFF);
        alloc(25'h0AA_AAAB);
        alloc(25'h055_5555);
        write_granule(0);
        alloc(7);
        alloc(25'h0FF_FFFF);
        write_granule(17'd65536);
        alloc(1);
        alloc(25'h100_0000);

        write_granule(1);
        random_requests(48);
        write_granule(17'd65536);
        random_requests(48);
        write_granule(0);
        random_requests(48);
        write_granule(17'd3);
        random_requests(48);
        write_granule(17'($urandom_range(1, 65536)));
        random_requests(48);

        // fill the hole store, then overflow it
        while (sb.hole_cnt < SLOTS)
            release_region($urandom, bfha_pkg::SIZE_W'($urandom_range(1000)));
        repeat (3) release_region($urandom, bfha_pkg::SIZE_W'($urandom_range(1000)));
        repeat (5) alloc(bfha_pkg::SIZE_W'($urandom_range(1000)));

        // run the file end into the top of the address space
        write_granule(17'd65536);
        guard = 0;
        while (sb.space_end + 64'h1FF_0000 <= OFF_MAX && guard < 400) begin
            alloc(25'h1FF_0000);
            guard++;
        end
        repeat (3) alloc(25'h1FF_0000);
        alloc(25'h100_0000);
        alloc(0);

        @(negedge i_clk);
        i_valid = 1'b0;
        while (sb.grants_due.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
